/* hw/rtl/uri_pkg.sv */
// uri_pkg: shared types and constants of the serial-port register block
// beat payload structs, bus modes, register offsets and fixed id values
// no dependencies
package uri_pkg;

  // input beat: bus read, bus write or console receive event
  typedef struct packed {
    logic [1:0]  mode;
    logic [11:0] offset;
    logic        word_access;
    logic [31:0] write_data;
    logic [7:0]  con_byte;
    logic        con_more;
    logic        con_error;
  } in_item_t;

  // result beat
  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_level;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        attach_request;
  } out_item_t;

  // handshake bundle between stages
  typedef struct packed {
    logic valid;
    logic ready;
  } stage_hs_t;

  // item modes
  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_RX    = 2'd2;

  // register offsets
  localparam logic [11:0] OFS_DATA  = 12'h000;
  localparam logic [11:0] OFS_ERR   = 12'h004;
  localparam logic [11:0] OFS_FLAGS = 12'h018;
  localparam logic [11:0] OFS_LINE  = 12'h02c;
  localparam logic [11:0] OFS_CTRL  = 12'h030;
  localparam logic [11:0] OFS_MASK  = 12'h038;
  localparam logic [11:0] OFS_RAW   = 12'h03c;
  localparam logic [11:0] OFS_CLEAR = 12'h044;
  localparam logic [11:0] OFS_PID0  = 12'hfe0;
  localparam logic [11:0] OFS_PID1  = 12'hfe4;
  localparam logic [11:0] OFS_PID2  = 12'hfe8;
  localparam logic [11:0] OFS_PID3  = 12'hfec;
  localparam logic [11:0] OFS_CID0  = 12'hff0;
  localparam logic [11:0] OFS_CID1  = 12'hff4;
  localparam logic [11:0] OFS_CID2  = 12'hff8;
  localparam logic [11:0] OFS_CID3  = 12'hffc;

  // fixed read values
  localparam logic [31:0] LINE_VALUE   = 32'h0000_0060;
  localparam logic [31:0] PID_WORD     = 32'h0034_1011;
  localparam logic [31:0] CID_WORD     = 32'hb105_f00d;
  localparam logic [7:0]  PID_BYTE0    = 8'h11;
  localparam logic [7:0]  PID_BYTE1    = 8'h10;
  localparam logic [7:0]  PID_BYTE2    = 8'h34;
  localparam logic [7:0]  PID_BYTE3    = 8'h00;
  localparam logic [7:0]  CID_BYTE0    = 8'h0d;
  localparam logic [7:0]  CID_BYTE1    = 8'hf0;
  localparam logic [7:0]  CID_BYTE2    = 8'h05;
  localparam logic [7:0]  CID_BYTE3    = 8'hb1;
  localparam logic [3:0]  ERR_ALL      = 4'hf;
  localparam logic [31:0] CTRL_RESET   = 32'h0000_0300;

endpackage

/* hw/rtl/uri_in_stage.sv */
// uri_in_stage: input register holding one accepted beat
// depends on uri_pkg
module uri_in_stage
  import uri_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output stage_hs_t hs,
  input  logic      take,
  output in_item_t  item
);

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;

  // room when empty or when the held beat leaves this cycle
  assign in_ready  = !valid_r || take;
  assign valid_nxt = (in_valid && in_ready) ? 1'b1 : (take ? 1'b0 : valid_r);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

  assign hs.valid = valid_r;
  assign hs.ready = take;
  assign item     = item_r;

endmodule

/* hw/rtl/uri_regs.sv */
// uri_regs: register state, read decode and write effects for one beat
// depends on uri_pkg
module uri_regs
  import uri_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  stage_hs_t in_hs,
  input  in_item_t  item,
  input  logic      push_ready,
  output logic      take,
  output out_item_t result
);

  logic [3:0]  error_bits_r,     error_bits_nxt;
  logic        rx_empty_r,       rx_empty_nxt;
  logic [31:0] control_word_r,   control_word_nxt;
  logic [31:0] interrupt_mask_r, interrupt_mask_nxt;
  logic        rx_raw_r,         rx_raw_nxt;
  logic        irq_pending_r,    irq_pending_nxt;
  logic [31:0] rd_data;

  // beat moves on when the result register has room
  assign take = in_hs.valid && push_ready;

  // read mux, on the state before this beat
  always_comb begin
    rd_data = '0;
    case (item.offset)
      OFS_DATA:  rd_data = item.con_error ? {20'd0, ERR_ALL, 8'd0}
                                          : {20'd0, error_bits_r, item.con_byte};
      OFS_ERR:   rd_data = {28'd0, error_bits_r};
      OFS_FLAGS: rd_data = {24'd0, 1'b1, 2'b00, rx_empty_r, 4'd0};
      OFS_LINE:  rd_data = LINE_VALUE;
      OFS_CTRL:  rd_data = control_word_r;
      OFS_MASK:  rd_data = interrupt_mask_r;
      OFS_RAW:   rd_data = {27'd0, rx_raw_r, 4'd0};
      OFS_PID0:  rd_data = item.word_access ? PID_WORD : {24'd0, PID_BYTE0};
      OFS_PID1:  rd_data = {24'd0, PID_BYTE1};
      OFS_PID2:  rd_data = {24'd0, PID_BYTE2};
      OFS_PID3:  rd_data = {24'd0, PID_BYTE3};
      OFS_CID0:  rd_data = item.word_access ? CID_WORD : {24'd0, CID_BYTE0};
      OFS_CID1:  rd_data = {24'd0, CID_BYTE1};
      OFS_CID2:  rd_data = {24'd0, CID_BYTE2};
      OFS_CID3:  rd_data = {24'd0, CID_BYTE3};
      default:   rd_data = '0;
    endcase
  end

  // state update and result
  always_comb begin
    error_bits_nxt     = error_bits_r;
    rx_empty_nxt       = rx_empty_r;
    control_word_nxt   = control_word_r;
    interrupt_mask_nxt = interrupt_mask_r;
    rx_raw_nxt         = rx_raw_r;
    irq_pending_nxt    = irq_pending_r;
    result             = '0;
    if (take) begin
      case (item.mode)
        MODE_READ: begin
          result.read_data = rd_data;
          if (item.offset == OFS_DATA) begin
            if (item.con_error) begin
              error_bits_nxt = ERR_ALL;
            end else begin
              rx_raw_nxt      = 1'b0;
              irq_pending_nxt = 1'b0;
              if (!item.con_more) begin
                rx_empty_nxt = 1'b1;
              end
            end
          end
        end
        MODE_WRITE: begin
          case (item.offset)
            OFS_DATA: begin
              result.tx_valid = 1'b1;
              result.tx_byte  = item.write_data[7:0];
            end
            OFS_ERR: error_bits_nxt = '0;
            OFS_CTRL: begin
              control_word_nxt      = item.write_data;
              result.attach_request = item.write_data[0] && item.write_data[9];
            end
            OFS_MASK: interrupt_mask_nxt = item.write_data;
            OFS_CLEAR: begin
              if (item.write_data[4]) begin
                rx_raw_nxt = 1'b0;
              end
            end
            default: ;
          endcase
        end
        MODE_RX: begin
          rx_empty_nxt    = 1'b0;
          rx_raw_nxt      = 1'b1;
          irq_pending_nxt = 1'b1;
        end
        default: ;
      endcase
    end
    result.irq_level = irq_pending_nxt;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_bits_r     <= '0;
      rx_empty_r       <= 1'b1;
      control_word_r   <= CTRL_RESET;
      interrupt_mask_r <= '0;
      rx_raw_r         <= 1'b0;
      irq_pending_r    <= 1'b0;
    end else begin
      error_bits_r     <= error_bits_nxt;
      rx_empty_r       <= rx_empty_nxt;
      control_word_r   <= control_word_nxt;
      interrupt_mask_r <= interrupt_mask_nxt;
      rx_raw_r         <= rx_raw_nxt;
      irq_pending_r    <= irq_pending_nxt;
    end
  end

`ifndef SYNTH
  // receive event raises the line and marks data waiting
  a_rx_event: assert property (@(posedge clk) disable iff (!rst_n)
    take && item.mode == MODE_RX |=> irq_pending_r && !rx_empty_r && rx_raw_r)
    else $error("receive event did not set status");

  // good data read drops the interrupt
  a_data_read: assert property (@(posedge clk) disable iff (!rst_n)
    take && item.mode == MODE_READ && item.offset == OFS_DATA && !item.con_error
    |=> !irq_pending_r && !rx_raw_r)
    else $error("data read did not clear interrupt");

  // state holds while no beat is processed
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !take |=> $stable(irq_pending_r) && $stable(control_word_r) && $stable(error_bits_r))
    else $error("state changed without a beat");
`endif

endmodule

/* hw/rtl/uri_out_stage.sv */
// uri_out_stage: result register towards the output channel
// depends on uri_pkg
module uri_out_stage
  import uri_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_item_t push_item,
  output logic      push_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic      valid_r;
  logic      valid_nxt;
  out_item_t data_r;

  // room when empty or when the held beat is taken this cycle
  assign push_ready = !valid_r || out_ready;
  assign valid_nxt  = push ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (push) begin
      data_r <= push_item;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

/* hw/rtl/uart_register_interface.sv */
// Serial-port register block: takes bus reads, bus writes and console receive
// events and returns one result beat for each. One beat is accepted per cycle
// when the result side keeps up; each beat passes the input register and then
// the result register, with all decode and state update done in the single
// logic level between them. in_ready drops only while both registers hold a
// beat and out_ready is low.
// depends on uri_pkg, uri_in_stage, uri_regs, uri_out_stage
module uart_register_interface
  import uri_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  stage_hs_t in_hs;
  in_item_t  item;
  logic      take;
  logic      push_ready;
  out_item_t result;

  // input register
  uri_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .hs       (in_hs),
    .take     (take),
    .item     (item)
  );

  // register state and decode
  uri_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_hs      (in_hs),
    .item       (item),
    .push_ready (push_ready),
    .take       (take),
    .result     (result)
  );

  // result register
  uri_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (take),
    .push_item  (result),
    .push_ready (push_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

/* tb/tb_uart_register_interface.sv */
`timescale 1ns / 1ps
// tb_uart_register_interface: self-checking bench for the serial-port register block
// random bus reads, writes and receive events with idling on both sides, checked beat by beat
// depends on uri_pkg and uart_register_interface
module tb_uart_register_interface
  import uri_pkg::*;
();

  localparam logic [1:0]  MODE_NONE     = 2'd3;
  localparam logic [31:0] FLAG_TX_EMPTY = 32'h0000_0080;
  localparam int          RX_EMPTY_BIT  = 4;
  localparam int          RAW_RX_BIT    = 4;
  localparam int          CLEAR_RX_BIT  = 4;
  localparam int          CTRL_EN_BIT   = 0;
  localparam int          CTRL_RXE_BIT  = 9;
  localparam int unsigned TOTAL_BEATS   = 1525;
  localparam int unsigned LONG_HOLD     = 120;
  localparam int unsigned DRAIN_CYCLES  = 10;
  localparam longint      TIMEOUT_NS    = 5_000_000;

  localparam logic [11:0] KNOWN_OFS [16] = '{
    OFS_DATA, OFS_ERR, OFS_FLAGS, OFS_LINE, OFS_CTRL, OFS_MASK, OFS_RAW, OFS_CLEAR,
    OFS_PID0, OFS_PID1, OFS_PID2, OFS_PID3, OFS_CID0, OFS_CID1, OFS_CID2, OFS_CID3
  };

  // register state mirror and queue of predicted result beats
  class uart_reg_scoreboard;
    logic [3:0]  err_nibble;
    logic        rx_empty;
    logic        rx_raw;
    logic        irq_pend;
    logic [31:0] ctrl_word;
    logic [31:0] irq_mask;
    out_item_t   pending_results[$];
    int unsigned mismatches;

    function new();
      err_nibble = '0;
      rx_empty   = 1'b1;
      rx_raw     = 1'b0;
      irq_pend   = 1'b0;
      ctrl_word  = CTRL_RESET;
      irq_mask   = '0;
      mismatches = 0;
    endfunction

    // updates the mirrored registers and returns the result beat of one access
    function out_item_t access_result(in_item_t it);
      out_item_t r;
      r = '0;
      case (it.mode)
        MODE_READ: begin
          case (it.offset)
            OFS_DATA: begin
              if (it.con_error) begin
                err_nibble = ERR_ALL;
                r.read_data = {20'd0, err_nibble, 8'd0};
              end else begin
                rx_raw = 1'b0;
                irq_pend = 1'b0;
                if (!it.con_more) rx_empty = 1'b1;
                // received byte in the low bits, error nibble above it, rest zero
                r.read_data = {20'd0, err_nibble, it.con_byte};
              end
            end
            OFS_ERR:   r.read_data = {28'd0, err_nibble};
            OFS_FLAGS: r.read_data = FLAG_TX_EMPTY | (32'(rx_empty) << RX_EMPTY_BIT);
            OFS_LINE:  r.read_data = LINE_VALUE;
            OFS_CTRL:  r.read_data = ctrl_word;
            OFS_MASK:  r.read_data = irq_mask;
            OFS_RAW:   r.read_data = 32'(rx_raw) << RAW_RX_BIT;
            OFS_PID0:  r.read_data = it.word_access ? PID_WORD : {24'd0, PID_BYTE0};
            OFS_PID1:  r.read_data = {24'd0, PID_BYTE1};
            OFS_PID2:  r.read_data = {24'd0, PID_BYTE2};
            OFS_PID3:  r.read_data = {24'd0, PID_BYTE3};
            OFS_CID0:  r.read_data = it.word_access ? CID_WORD : {24'd0, CID_BYTE0};
            OFS_CID1:  r.read_data = {24'd0, CID_BYTE1};
            OFS_CID2:  r.read_data = {24'd0, CID_BYTE2};
            OFS_CID3:  r.read_data = {24'd0, CID_BYTE3};
            default:   r.read_data = '0;
          endcase
        end
        MODE_WRITE: begin
          case (it.offset)
            OFS_DATA: begin
              r.tx_valid = 1'b1;
              r.tx_byte = it.write_data[7:0];
            end
            OFS_ERR: err_nibble = '0;
            OFS_CTRL: begin
              ctrl_word = it.write_data;
              r.attach_request = it.write_data[CTRL_EN_BIT] & it.write_data[CTRL_RXE_BIT];
            end
            OFS_MASK: irq_mask = it.write_data;
            // write-one-to-clear of the raw receive bit, line level untouched
            OFS_CLEAR: begin
              if (it.write_data[CLEAR_RX_BIT]) rx_raw = 1'b0;
            end
            default: ;
          endcase
        end
        MODE_RX: begin
          rx_empty = 1'b0;
          rx_raw = 1'b1;
          irq_pend = 1'b1;
        end
        default: ;
      endcase
      r.irq_level = irq_pend;
      return r;
    endfunction

    function void note_input(in_item_t it);
      pending_results.push_back(access_result(it));
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: %h", got);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      if (got.read_data !== want.read_data) begin
        $error("read_data expected %h got %h", want.read_data, got.read_data);
        mismatches++;
      end
      if (got.irq_level !== want.irq_level) begin
        $error("irq_level expected %b got %b", want.irq_level, got.irq_level);
        mismatches++;
      end
      if (got.tx_valid !== want.tx_valid) begin
        $error("tx_valid expected %b got %b", want.tx_valid, got.tx_valid);
        mismatches++;
      end
      if (got.tx_byte !== want.tx_byte) begin
        $error("tx_byte expected %h got %h", want.tx_byte, got.tx_byte);
        mismatches++;
      end
      if (got.attach_request !== want.attach_request) begin
        $error("attach_request expected %b got %b", want.attach_request, got.attach_request);
        mismatches++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  uart_reg_scoreboard sb = new();
  bit          quiet;
  bit          calm;
  bit          long_hold_req;
  int unsigned sent_count;

  uart_register_interface u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // result monitor, values sampled before the edge updates
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  function automatic in_item_t make_beat(logic [1:0] mode, logic [11:0] ofs,
                                         logic word = 1'b0, logic [31:0] wdata = '0,
                                         logic [7:0] cb = '0, logic more = 1'b0,
                                         logic fail = 1'b0);
    in_item_t it;
    it.mode = mode;
    it.offset = ofs;
    it.word_access = word;
    it.write_data = wdata;
    it.con_byte = cb;
    it.con_more = more;
    it.con_error = fail;
    return it;
  endfunction

  // mostly mapped offsets, some unaligned and some anywhere in the window
  function automatic in_item_t random_beat();
    in_item_t    it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) it.mode = MODE_READ;
    else if (pick < 80) it.mode = MODE_WRITE;
    else if (pick < 95) it.mode = MODE_RX;
    else it.mode = MODE_NONE;
    pick = $urandom_range(0, 9);
    if (pick < 8) it.offset = KNOWN_OFS[$urandom_range(0, 15)];
    else if (pick == 8) it.offset = KNOWN_OFS[$urandom_range(0, 15)] | 12'($urandom_range(1, 3));
    else it.offset = 12'($urandom);
    it.word_access = 1'($urandom);
    it.write_data = $urandom;
    it.con_byte = 8'($urandom);
    it.con_more = 1'($urandom);
    it.con_error = ($urandom_range(0, 7) == 0);
    return it;
  endfunction

  // optional idle burst, then hold the beat until it is taken
  task automatic offer(input in_item_t it);
    int unsigned n;
    if (!quiet && !calm && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 14);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(it);
    sent_count++;
  endtask

  // receive event, status reads, an optional clear write and the data read that consumes it
  task automatic receive_sequence();
    in_item_t seq [5];
    seq[0] = random_beat();
    seq[0].mode = MODE_RX;
    seq[1] = make_beat(MODE_READ, OFS_RAW);
    seq[2] = make_beat(MODE_WRITE, OFS_CLEAR, 1'b1, $urandom);
    seq[3] = make_beat(MODE_READ, OFS_DATA, 1'b1, '0, 8'($urandom), 1'($urandom),
                       $urandom_range(0, 9) == 0);
    seq[4] = make_beat(MODE_READ, OFS_FLAGS);
    foreach (seq[i]) begin
      if (i != 2 || $urandom_range(0, 1) == 0) offer(seq[i]);
    end
  endtask

  // wait until every predicted beat has come back, valid low meanwhile
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  // result side stalls: short bursts, ready stretches and one long hold-off
  initial begin
    int unsigned n;
    out_ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 14);
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : 1;
        out_ready <= 1'b1;
        repeat (n) @(posedge clk);
      end
    end
  end

  // stimulus
  initial begin
    bit hold_done;
    bit drain_done;
    hold_done = 1'b0;
    drain_done = 1'b0;
    quiet = 1'b0;
    calm = 1'b0;
    long_hold_req = 1'b0;
    sent_count = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset values, error nibble, receive path, transmit, control and mask writes, identification words
    offer(make_beat(MODE_READ, OFS_FLAGS));
    offer(make_beat(MODE_READ, OFS_CTRL));
    offer(make_beat(MODE_READ, OFS_DATA, 1'b0, '0, 8'hff, 1'b0, 1'b1));
    offer(make_beat(MODE_READ, OFS_ERR));
    offer(make_beat(MODE_WRITE, OFS_ERR, 1'b1, '0));
    offer(make_beat(MODE_RX, OFS_DATA));
    offer(make_beat(MODE_READ, OFS_RAW));
    offer(make_beat(MODE_WRITE, OFS_CLEAR, 1'b1, 32'hffff_ffef));
    offer(make_beat(MODE_WRITE, OFS_CLEAR, 1'b1, 32'h0000_0010));
    offer(make_beat(MODE_READ, OFS_RAW));
    offer(make_beat(MODE_READ, OFS_DATA, 1'b1, '0, 8'hff, 1'b1, 1'b0));
    offer(make_beat(MODE_READ, OFS_FLAGS));
    offer(make_beat(MODE_RX, 12'hfff, 1'b1, 32'hffff_ffff, 8'hff, 1'b1, 1'b1));
    offer(make_beat(MODE_READ, OFS_DATA, 1'b1, '0, 8'h80, 1'b0, 1'b0));
    offer(make_beat(MODE_WRITE, OFS_DATA, 1'b1, 32'hffff_ffff));
    offer(make_beat(MODE_WRITE, OFS_CTRL, 1'b1, 32'h0000_0201));
    offer(make_beat(MODE_WRITE, OFS_CTRL, 1'b1, 32'hffff_ffff));
    offer(make_beat(MODE_WRITE, OFS_CTRL, 1'b1, 32'h0000_0200));
    offer(make_beat(MODE_WRITE, OFS_MASK, 1'b1, 32'hffff_ffff));
    offer(make_beat(MODE_READ, OFS_MASK, 1'b1));
    offer(make_beat(MODE_READ, OFS_PID0, 1'b1));
    offer(make_beat(MODE_READ, OFS_CID0, 1'b1));
    offer(make_beat(MODE_READ, OFS_CID3));
    offer(make_beat(MODE_READ, 12'h031, 1'b1));
    offer(make_beat(MODE_NONE, OFS_CTRL, 1'b1, 32'hffff_ffff, 8'hff, 1'b1, 1'b1));
    pause_until_drained();

    // random traffic, with receive sequences mixed in
    while (sent_count < TOTAL_BEATS) begin
      if ($urandom_range(0, 99) == 0) calm = !calm;
      if (!hold_done && sent_count > TOTAL_BEATS / 4) begin
        long_hold_req = 1'b1;
        hold_done = 1'b1;
      end
      if (!drain_done && sent_count > TOTAL_BEATS / 2) begin
        pause_until_drained();
        drain_done = 1'b1;
      end
      if (sent_count > TOTAL_BEATS * 9 / 10) quiet = 1'b1;
      if ($urandom_range(0, 9) < 3) receive_sequence();
      else offer(random_beat());
    end

    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("** uart_register_interface: PASSED **");
    end else begin
      $display("** uart_register_interface: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #TIMEOUT_NS;
    $display("** uart_register_interface: FAILED **");
    $finish;
  end

endmodule
